// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [15:0] CH_QUOTE   = 16'h0022;
    localparam logic [15:0] CH_SLASH   = 16'h002F;
    localparam logic [15:0] CH_BSLASH  = 16'h005C;
    localparam logic [15:0] CH_LOW_B   = 16'h0062;
    localparam logic [15:0] CH_LOW_F   = 16'h0066;
    localparam logic [15:0] CH_LOW_N   = 16'h006E;
    localparam logic [15:0] CH_LOW_R   = 16'h0072;
    localparam logic [15:0] CH_LOW_T   = 16'h0074;
    localparam logic [15:0] CH_LOW_U   = 16'h0075;
    localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
    localparam logic [15:0] CH_UP_A    = 16'h0041;
    localparam logic [15:0] CH_UP_F    = 16'h0046;
    localparam logic [15:0] CH_LOW_A   = 16'h0061;

    localparam logic [15:0] CTL_BS  = 16'h0008;
    localparam logic [15:0] CTL_TAB = 16'h0009;
    localparam logic [15:0] CTL_LF  = 16'h000A;
    localparam logic [15:0] CTL_FF  = 16'h000C;
    localparam logic [15:0] CTL_CR  = 16'h000D;

    localparam logic [3:0] HEX_ALPHA_ADJ = 4'd9;

    typedef struct packed {
        logic        text_end;
        logic        is_quote;
        logic        is_bslash;
        logic        esc_ok;
        logic [15:0] esc_ch;
        logic        is_u;
        logic        hex_ok;
        logic [3:0]  hex_val;
        logic [15:0] ch;
    } t_cls;

endpackage

// ===== sv/jsu_if.sv =====
interface jsu_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] text_char;

    modport source (output valid, output action, output text_char, input ready);
    modport sink (input valid, input action, input text_char, output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] decoded_char;
    logic [15:0] consumed;

    modport source (output valid, output kind, output decoded_char, output consumed,
                    input ready);
    modport sink (input valid, input kind, input decoded_char, input consumed,
                  output ready);
endinterface

// ===== sv/jsu_front.sv =====
module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jsu_in_if.sink         i_in,
    output logic           o_push_valid,
    output jsu_pkg::t_cls  o_push_cls,
    input  logic           i_push_ready
);
    import jsu_pkg::*;

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;
    logic accept;

    always_comb begin
        n_cls           = '0;
        n_cls.text_end  = i_in.action;
        n_cls.ch        = i_in.text_char;
        n_cls.is_quote  = (i_in.text_char == CH_QUOTE);
        n_cls.is_bslash = (i_in.text_char == CH_BSLASH);
        n_cls.is_u      = (i_in.text_char == CH_LOW_U);
        n_cls.esc_ok    = 1'b1;
        unique case (i_in.text_char)
            CH_QUOTE, CH_SLASH, CH_BSLASH: n_cls.esc_ch = i_in.text_char;
            CH_LOW_B: n_cls.esc_ch = CTL_BS;
            CH_LOW_F: n_cls.esc_ch = CTL_FF;
            CH_LOW_N: n_cls.esc_ch = CTL_LF;
            CH_LOW_R: n_cls.esc_ch = CTL_CR;
            CH_LOW_T: n_cls.esc_ch = CTL_TAB;
            default: begin
                n_cls.esc_ok = 1'b0;
                n_cls.esc_ch = '0;
            end
        endcase
        if (i_in.text_char >= CH_DIGIT_0 && i_in.text_char <= CH_DIGIT_9) begin
            n_cls.hex_ok  = 1'b1;
            n_cls.hex_val = i_in.text_char[3:0];
        end else if ((i_in.text_char >= CH_UP_A && i_in.text_char <= CH_UP_F) ||
                     (i_in.text_char >= CH_LOW_A && i_in.text_char <= CH_LOW_F)) begin
            n_cls.hex_ok  = 1'b1;
            n_cls.hex_val = 4'(i_in.text_char[3:0] + HEX_ALPHA_ADJ);
        end else begin
            n_cls.hex_ok  = 1'b0;
            n_cls.hex_val = '0;
        end
    end

    assign i_in.ready   = !r_valid || i_push_ready;
    assign accept       = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_push_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== sv/jsu_queue.sv =====
module jsu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  jsu_pkg::t_cls  i_push_cls,
    output logic           o_push_ready,
    output logic           o_head_valid,
    output jsu_pkg::t_cls  o_head_cls,
    input  logic           i_pop
);
    import jsu_pkg::*;

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   r_wr_ptr;
    logic [QUEUE_AW:0]   r_rd_ptr;
    logic                full;
    logic                empty;
    logic                push;

    assign empty = (r_wr_ptr == r_rd_ptr);
    assign full  = (r_wr_ptr[QUEUE_AW] != r_rd_ptr[QUEUE_AW]) &&
                   (r_wr_ptr[QUEUE_AW-1:0] == r_rd_ptr[QUEUE_AW-1:0]);
    assign o_push_ready = !full;
    assign push         = i_push_valid && !full;
    assign o_head_valid = !empty;
    assign o_head_cls   = r_mem[r_rd_ptr[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr[QUEUE_AW-1:0]] <= i_push_cls;
        end
    end

endmodule

// ===== sv/jsu_back.sv =====
module jsu_back #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  jsu_pkg::t_cls  i_head_cls,
    output logic           o_pop,
    jsu_out_if.source      o_out
);
    import jsu_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;
    localparam logic [1:0] HEX_LAST = 2'd3;

    logic [1:0]             r_phase, n_phase;
    logic [1:0]             r_seen, n_seen;
    logic [11:0]            r_acc, n_acc;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   emit;
    logic [1:0]             e_kind;
    logic [15:0]            e_char;
    logic [COUNT_WIDTH-1:0] e_cnt;
    logic [31:0]            e_cnt_wide;
    logic                   r_ov;
    logic [1:0]             r_kind;
    logic [15:0]            r_char;
    logic [15:0]            r_consumed;
    t_cls                   h;

    assign h       = i_head_cls;
    assign cnt_inc = (&r_cnt) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
    assign o_pop   = i_head_valid && (!r_ov || o_out.ready);

    always_comb begin
        n_phase = r_phase;
        n_seen  = r_seen;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        e_kind  = KIND_CHAR;
        e_char  = '0;
        e_cnt   = '0;
        if (h.text_end) begin
            emit   = 1'b1;
            e_kind = KIND_ERROR;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (!h.is_quote) begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                    end else begin
                        n_phase = PH_BODY;
                        n_cnt   = COUNT_WIDTH'(1);
                    end
                end
                PH_BODY: begin
                    n_cnt = cnt_inc;
                    if (h.is_quote) begin
                        emit   = 1'b1;
                        e_kind = KIND_DONE;
                        e_cnt  = cnt_inc;
                    end else if (h.is_bslash) begin
                        n_phase = PH_ESC;
                    end else begin
                        emit   = 1'b1;
                        e_char = h.ch;
                    end
                end
                PH_ESC: begin
                    n_cnt = cnt_inc;
                    if (h.esc_ok) begin
                        emit    = 1'b1;
                        e_char  = h.esc_ch;
                        n_phase = PH_BODY;
                    end else if (h.is_u) begin
                        n_phase = PH_HEX;
                        n_seen  = '0;
                        n_acc   = '0;
                    end else begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                    end
                end
                PH_HEX: begin
                    if (!h.hex_ok) begin
                        emit   = 1'b1;
                        e_kind = KIND_ERROR;
                    end else begin
                        n_cnt = cnt_inc;
                        if (r_seen == HEX_LAST) begin
                            emit    = 1'b1;
                            e_char  = {r_acc, h.hex_val};
                            n_phase = PH_BODY;
                            n_seen  = '0;
                            n_acc   = '0;
                        end else begin
                            n_acc  = {r_acc[7:0], h.hex_val};
                            n_seen = r_seen + 2'd1;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
        // A finished string and every error leave the decoder idle and cleared.
        if (emit && e_kind != KIND_CHAR) begin
            n_phase = PH_IDLE;
            n_seen  = '0;
            n_acc   = '0;
            n_cnt   = '0;
        end
    end

    assign e_cnt_wide = 32'(e_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_seen  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_seen  <= n_seen;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_ov    <= emit;
            end else if (o_out.ready) begin
                r_ov    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind     <= e_kind;
            r_char     <= e_char;
            r_consumed <= (e_cnt_wide > 32'h0000FFFF) ? 16'hFFFF : e_cnt_wide[15:0];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.kind         = r_kind;
    assign o_out.decoded_char = r_char;
    assign o_out.consumed     = r_consumed;

endmodule

// ===== sv/json_string_unescape_core.sv =====
// A word accepted at a clock edge passes through the front register, the queue and the result
// register before its result word appears.
// Throughput: one word per cycle while result words are taken; the decoder state update in the back
// stage takes one word per cycle, and the four-entry queue absorbs stalls between the two stages.
// Reset: synchronous, active low; it empties the queue and the result register and returns
// the decoder to idle with its counters cleared at the next edge.
module json_string_unescape_core #(
    parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic push_valid;
    logic push_ready;
    t_cls push_cls;
    logic head_valid;
    t_cls head_cls;
    logic pop;

    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_cls   (push_cls),
        .i_push_ready (push_ready)
    );

    jsu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cls   (push_cls),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head_cls   (head_cls),
        .i_pop        (pop)
    );

    jsu_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cls   (head_cls),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ===== sv/jsu_checker.sv =====
module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_kind,
    input logic [15:0] i_out_char,
    input logic [15:0] i_out_consumed
);
    import jsu_pkg::*;

    // A stalled result word keeps its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_char) &&
            $stable(i_out_consumed))
        else $error("result word changed while stalled");

    assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A completed string always counts at least both quotes and carries no character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_DONE |->
            i_out_char == 16'h0000 && i_out_consumed >= 16'd2)
        else $error("bad completion word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_CHAR || i_out_kind == KIND_ERROR) |->
            i_out_consumed == 16'h0000)
        else $error("count reported outside a completion word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_ERROR |-> i_out_char == 16'h0000)
        else $error("error word carries a character");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_kind     (o_out.kind),
    .i_out_char     (o_out.decoded_char),
    .i_out_consumed (o_out.consumed)
);

// ===== sim/json_string_unescape_core_test.sv =====
module json_string_unescape_core_test;
    import jsu_pkg::*;

    localparam int COUNT_W     = COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } t_parse_phase;

    // The tracker decodes every accepted input word the way the block should and keeps
    // the result words that are still due.
    class unescape_tracker;
        typedef struct {
            logic [1:0]  kind;
            logic [15:0] ch;
            logic [15:0] cnt;
        } t_result_word;

        t_result_word    expected_words[$];
        t_parse_phase    phase;
        int unsigned     hex_seen;
        logic [15:0]     hex_acc;
        longint unsigned count;
        longint unsigned count_max;
        int              errors;

        function new(int count_width);
            count_max = (64'd1 << count_width) - 1;
            errors    = 0;
            restart();
        endfunction

        function void restart();
            phase    = PH_IDLE;
            hex_seen = 0;
            hex_acc  = '0;
            count    = 0;
        endfunction

        function void bump();
            if (count < count_max) begin
                count++;
            end
        endfunction

        function void push(logic [1:0] kind, logic [15:0] ch, longint unsigned cnt);
            t_result_word r;
            r.kind = kind;
            r.ch   = ch;
            r.cnt  = (cnt > 64'hFFFF) ? 16'hFFFF : cnt[15:0];
            expected_words.push_back(r);
        endfunction

        function void fail_parse();
            restart();
            push(KIND_ERROR, '0, 0);
        endfunction

        function int hex_digit(logic [15:0] c);
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                return int'(c - CH_DIGIT_0);
            end
            if (c >= CH_UP_A && c <= CH_UP_F) begin
                return int'(c - CH_UP_A) + 10;
            end
            if (c >= CH_LOW_A && c <= CH_LOW_F) begin
                return int'(c - CH_LOW_A) + 10;
            end
            return -1;
        endfunction

        function void emit_char(logic [15:0] c);
            phase = PH_BODY;
            push(KIND_CHAR, c, 0);
        endfunction

        function void decode_word(bit act, logic [15:0] c);
            int              d;
            longint unsigned n;
            if (act) begin
                fail_parse();
                return;
            end
            case (phase)
                PH_IDLE: begin
                    if (c != CH_QUOTE) begin
                        fail_parse();
                    end else begin
                        restart();
                        phase = PH_BODY;
                        bump();
                    end
                end
                PH_BODY: begin
                    bump();
                    if (c == CH_QUOTE) begin
                        n = count;
                        restart();
                        push(KIND_DONE, '0, n);
                    end else if (c == CH_BSLASH) begin
                        phase = PH_ESC;
                    end else begin
                        push(KIND_CHAR, c, 0);
                    end
                end
                PH_ESC: begin
                    bump();
                    case (c)
                        CH_QUOTE, CH_SLASH, CH_BSLASH: emit_char(c);
                        CH_LOW_B: emit_char(CTL_BS);
                        CH_LOW_F: emit_char(CTL_FF);
                        CH_LOW_N: emit_char(CTL_LF);
                        CH_LOW_R: emit_char(CTL_CR);
                        CH_LOW_T: emit_char(CTL_TAB);
                        CH_LOW_U: begin
                            phase    = PH_HEX;
                            hex_seen = 0;
                            hex_acc  = '0;
                        end
                        default: fail_parse();
                    endcase
                end
                default: begin
                    d = hex_digit(c);
                    if (d < 0) begin
                        fail_parse();
                    end else begin
                        bump();
                        hex_acc  = {hex_acc[11:0], 4'(d)};
                        hex_seen = (hex_seen + 1) & 7;
                        if (hex_seen >= 4) begin
                            emit_char(hex_acc);
                            hex_seen = 0;
                            hex_acc  = '0;
                        end
                    end
                end
            endcase
        endfunction

        function void check_word(logic [1:0] kind, logic [15:0] ch, logic [15:0] cnt);
            t_result_word e;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: kind %0d, decoded_char %h, consumed %0d",
                       kind, ch, cnt);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (ch !== e.ch) begin
                $error("decoded_char: expected %h, actual %h", e.ch, ch);
                errors++;
            end
            if (cnt !== e.cnt) begin
                $error("consumed: expected %0d, actual %0d", e.cnt, cnt);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_core #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    unescape_tracker tracker;
    int              src_max_gap;
    int              sink_max_gap;
    int              hold_cycles;
    int              words_sent;
    int              cycles;

    logic [15:0] esc_letters [8] = '{CH_QUOTE, CH_SLASH, CH_BSLASH, CH_LOW_B,
                                     CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
    logic [15:0] near_hex [6] = '{CH_DIGIT_0 - 16'd1, CH_DIGIT_9 + 16'd1, CH_UP_A - 16'd1,
                                  CH_UP_F + 16'd1, CH_LOW_A - 16'd1, CH_LOW_F + 16'd1};

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        cycles = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(bit act, logic [15:0] c);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.text_char <= c;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        tracker.decode_word(act, c);
        words_sent++;
    endtask

    task automatic send_char(logic [15:0] c);
        send_word(1'b0, c);
    endtask

    function automatic logic [15:0] plain_char();
        logic [15:0] c;
        do begin
            c = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(16'h20, 16'h7E));
        end while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [15:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) begin
            return CH_DIGIT_0 + 16'(v);
        end
        if (v < 16) begin
            return CH_UP_A + 16'(v - 10);
        end
        return CH_LOW_A + 16'(v - 16);
    endfunction

    task automatic wait_all_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (tracker.expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    // Mostly well-formed strings with random content; some are cut short by a bad
    // escape, a bad hex digit or the end of the text.
    task automatic random_string();
        int len;
        int r;
        int k;
        len = $urandom_range(0, 12);
        send_char(CH_QUOTE);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_char(plain_char());
            end else if (r < 75) begin
                send_char(CH_BSLASH);
                send_char(esc_letters[$urandom_range(0, 7)]);
            end else if (r < 90) begin
                send_char(CH_BSLASH);
                send_char(CH_LOW_U);
                repeat (4) send_char(hex_char());
            end else if (r < 93) begin
                send_char(CH_BSLASH);
                send_char(16'($urandom_range(0, 65535)));
                return;
            end else if (r < 96) begin
                send_char(CH_BSLASH);
                send_char(CH_LOW_U);
                k = $urandom_range(0, 3);
                repeat (k) send_char(hex_char());
                if ($urandom_range(0, 1) != 0) begin
                    send_char(near_hex[$urandom_range(0, 5)]);
                end else begin
                    send_char(16'($urandom_range(0, 65535)));
                end
                return;
            end else begin
                send_word(1'b1, 16'($urandom_range(0, 65535)));
                return;
            end
        end
        send_char(CH_QUOTE);
    endtask

    task automatic random_segment(int words, int src_gap, int sink_gap);
        int stop_at;
        src_max_gap  = src_gap;
        sink_max_gap = sink_gap;
        stop_at      = words_sent + words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
            end else begin
                random_string();
            end
        end
        wait_all_results();
    endtask

    initial begin
        int gap;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, sink_max_gap);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (out_if.valid !== 1'b1);
            tracker.check_word(out_if.kind, out_if.decoded_char, out_if.consumed);
        end
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.action    = 1'b0;
        in_if.text_char = '0;
        i_rst_n         = 1'b0;
        src_max_gap     = 3;
        sink_max_gap    = 3;
        hold_cycles     = 0;
        words_sent      = 0;
        tracker         = new(COUNT_W);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(1'b1, 16'hFFFF);
        send_char(16'h0078);
        send_char(CH_QUOTE);
        send_char(16'hFFFF);
        send_char(16'h0000);
        send_char(CH_BSLASH);
        send_char(CH_QUOTE);
        send_char(CH_BSLASH);
        send_char(CH_SLASH);
        send_char(CH_BSLASH);
        send_char(CH_BSLASH);
        send_char(CH_BSLASH);
        send_char(CH_LOW_N);
        send_char(CH_BSLASH);
        send_char(CH_LOW_U);
        send_char(CH_UP_F);
        send_char(CH_LOW_A);
        send_char(CH_DIGIT_9);
        send_char(CH_DIGIT_0);
        send_char(CH_QUOTE);
        send_char(CH_QUOTE);
        send_char(CH_BSLASH);
        send_char(16'h0071);
        send_char(CH_QUOTE);
        send_char(CH_BSLASH);
        send_char(CH_LOW_U);
        send_char(CH_UP_F + 16'd1);
        send_char(CH_QUOTE);
        send_word(1'b1, 16'h0000);
        wait_all_results();

        random_segment(500, 10, 10);

        hold_cycles = 400;
        random_segment(500, 0, 10);

        random_segment(500, 0, 0);
        random_segment(500, 10, 0);

        if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/jsu_pkg.sv
sv/jsu_if.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_core.sv
sv/jsu_checker.sv
sim/json_string_unescape_core_test.sv
